// ----- rtl/ftpe_pkg.sv -----
// Package: shared types, constants and modes for the fault table.
`timescale 1ns / 1ps
package ftpe_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [4:0]  CAP_RESET    = 5'd9;
    localparam logic [31:0] LIMIT_RESET  = 32'd5;
    localparam logic [47:0] WINDOW_RESET = 48'd60000000;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_CLEAR  = 3'd2,
        MODE_CHECK  = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_CAPACITY = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_WINDOW   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_TOP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [1:0]  level;
        logic        done;
        logic [47:0] stamp;
    } entry_t;

    // Control from the sequencer to the cell row.
    typedef struct packed {
        logic shift;    // cells at or after sel_pos take the right neighbor
        logic append;   // cell at wr_pos loads the new entry
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] fault_key;
        logic [1:0]  fault_level;
        logic        fault_done;
        logic [47:0] now_us;
        logic [3:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [4:0]  entry_count;
        logic [3:0]  top_index;
        logic [31:0] top_key;
        logic [1:0]  top_level;
        logic        cascading;
        logic [31:0] read_key;
        logic [1:0]  read_level;
        logic        read_done;
        logic [47:0] read_time;
    } out_item_t;
endpackage

// ----- rtl/ftpe_cell.sv -----
// One table cell: holds one entry, shifts left from its neighbor or loads.
`timescale 1ns / 1ps
module ftpe_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            load_en,
    input  ftpe_pkg::entry_t right_in,
    input  ftpe_pkg::entry_t load_in,
    output ftpe_pkg::entry_t q
);
    import ftpe_pkg::*;

    entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            q_reg <= load_in;
        end
        else if (shift_en)
        begin
            q_reg <= right_in;
        end
    end

    assign q = q_reg;
endmodule

// ----- rtl/ftpe_row.sv -----
// Row of cells forming the ordered table; gap closing shifts all cells at or right of the gap together.
`timescale 1ns / 1ps
module ftpe_row #(
    parameter int N  = ftpe_pkg::MAX_ENTRIES_DEF,
    parameter int IW = (N > 1) ? $clog2(N) : 1
) (
    input  logic              clk,
    input  ftpe_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]     sel_pos,
    input  logic [IW-1:0]     wr_pos,
    input  ftpe_pkg::entry_t  new_entry,
    output ftpe_pkg::entry_t  cells [N]
);
    import ftpe_pkg::*;

    // Closing the gap at sel_pos: every cell at or right of it copies its
    // right neighbor, all at once (each cell sees only its neighbor).
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        entry_t right;
        if (g + 1 < N)
        begin : g_mid
            assign right = cells[g+1];
        end
        else
        begin : g_end
            assign right = cells[g];
        end
        ftpe_cell u_cell (
            .clk      (clk),
            .shift_en (ctl.shift && (IW'(g) >= sel_pos)),
            .load_en  (ctl.append && (IW'(g) == wr_pos)),
            .right_in (right),
            .load_in  (new_entry),
            .q        (cells[g])
        );
    end
endmodule

// ----- rtl/fault_table_priority_evict.sv -----
// Top level: fault table with priority eviction and cascade detection.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off by the receiver.
// Add and remove walk the table one entry per cycle with a shared scan
// counter: a victim scan (add at capacity only) or match scan over the held
// entries, a gap shift, then a priority scan over the new contents, and a
// closing state; the result shows in the same cycle that busy drops. Clear,
// cascade check and read go straight to the closing state, with the result
// likewise in the same cycle that busy drops. Entries live in a row of cells;
// the scan counter is the only walker over them.
module fault_table_priority_evict #(
    parameter int MAX_ENTRIES = ftpe_pkg::MAX_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ftpe_pkg::in_item_t  in_item,
    output logic               done,
    output ftpe_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import ftpe_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // configuration
    logic [4:0]  cap_reg;
    logic [31:0] limit_reg;
    logic [47:0] window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            limit_reg  <= LIMIT_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAPACITY: cap_reg    <= cfg_data[4:0];
                REG_LIMIT:    limit_reg  <= cfg_data[31:0];
                REG_WINDOW:   window_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // effective capacity: zero acts as 9, clipped to the table size
    // (a table of 32 or more can never be below the 5-bit register)
    logic [5:0] cap_eff;
    always_comb
    begin
        cap_eff = (cap_reg == 5'd0) ? 6'd9 : {1'b0, cap_reg};
        if (MAX_ENTRIES < 32 && cap_eff > 6'(MAX_ENTRIES))
        begin
            cap_eff = 6'(MAX_ENTRIES);
        end
    end

    // state
    state_t          state_reg, state_next;
    in_item_t        item_reg, item_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     wfaults_reg, wfaults_next;
    logic [47:0]     wstart_reg, wstart_next;
    logic            casc_reg, casc_next;
    logic [IW-1:0]   top_reg, top_next;
    logic [CW-1:0]   scan_reg, scan_next;   // walker position
    logic [IW-1:0]   best_reg, best_next;   // victim/match candidate
    logic [1:0]      blvl_reg, blvl_next;
    logic            bres_reg, bres_next;
    logic            found_reg, found_next;
    logic            ok_reg, ok_next;
    logic            ev_reg, ev_next;
    logic [31:0]     evkey_reg, evkey_next;

    cell_ctl_t       ctl;
    entry_t          cells [MAX_ENTRIES];
    entry_t          new_entry;
    logic [IW-1:0]   wr_pos;
    entry_t          cur;

    assign new_entry = '{key: item_reg.fault_key, level: item_reg.fault_level,
                         done: item_reg.fault_done, stamp: item_reg.now_us};
    assign cur = cells[scan_reg[IW-1:0]];

    ftpe_row #(.N(MAX_ENTRIES), .IW(IW)) u_row (
        .clk       (clk),
        .ctl       (ctl),
        .sel_pos   (best_reg),
        .wr_pos    (wr_pos),
        .new_entry (new_entry),
        .cells     (cells)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            wfaults_reg <= '0;
            wstart_reg  <= '0;
            casc_reg    <= 1'b0;
            top_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wfaults_reg <= wfaults_next;
            wstart_reg  <= wstart_next;
            casc_reg    <= casc_next;
            top_reg     <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        scan_reg  <= scan_next;
        best_reg  <= best_next;
        blvl_reg  <= blvl_next;
        bres_reg  <= bres_next;
        found_reg <= found_next;
        ok_reg    <= ok_next;
        ev_reg    <= ev_next;
        evkey_reg <= evkey_next;
    end

    logic [47:0] elapsed;
    assign elapsed = item_reg.now_us - wstart_reg;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        wfaults_next = wfaults_reg;
        wstart_next  = wstart_reg;
        casc_next    = casc_reg;
        top_next     = top_reg;
        scan_next    = scan_reg;
        best_next    = best_reg;
        blvl_next    = blvl_reg;
        bres_next    = bres_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        ev_next      = ev_reg;
        evkey_next   = evkey_reg;
        ctl          = '0;
        wr_pos       = count_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = in_item;
                    ok_next    = 1'b0;
                    ev_next    = 1'b0;
                    evkey_next = '0;
                    found_next = 1'b0;
                    scan_next  = '0;
                    best_next  = '0;
                    case (in_item.mode)
                        MODE_ADD:
                        begin
                            ok_next = 1'b1;
                            if ({1'b0, count_next} >= cap_eff && count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_SHIFT;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // add: victim search; remove: first id match
                if (item_reg.mode == MODE_ADD)
                begin
                    if (scan_reg == '0 ||
                        (cur.done && !bres_reg) ||
                        (cur.done == bres_reg && cur.level < blvl_reg))
                    begin
                        best_next = scan_reg[IW-1:0];
                        blvl_next = cur.level;
                        bres_next = cur.done;
                        evkey_next = cur.key;
                    end
                    found_next = 1'b1;
                end
                else if (!found_reg && cur.key == item_reg.fault_key)
                begin
                    best_next  = scan_reg[IW-1:0];
                    found_next = 1'b1;
                end
                if (scan_reg + 1'b1 >= count_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (item_reg.mode == MODE_ADD)
                begin
                    if (found_reg)
                    begin
                        ctl.shift  = 1'b1;
                        ev_next    = 1'b1;
                    end
                    // append at the end while the gap closes; shifting and loading share
                    // the edge, load wins at the write slot
                    if (found_reg)
                    begin
                        wr_pos = IW'(count_reg - 1'b1);
                        ctl.append = 1'b1;
                    end
                    else if (count_reg < CW'(MAX_ENTRIES))
                    begin
                        ctl.append = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (wfaults_reg != '1)
                    begin
                        wfaults_next = wfaults_reg + 1'b1;
                    end
                    scan_next  = '0;
                    state_next = ST_TOP;
                end
                else if (found_reg)
                begin
                    ctl.shift  = 1'b1;
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                    scan_next  = '0;
                    state_next = (count_reg == CW'(1)) ? ST_DONE : ST_TOP;
                    if (count_reg == CW'(1))
                    begin
                        top_next = '0;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TOP:
            begin
                if (scan_reg == '0 || cur.level > blvl_reg)
                begin
                    top_next  = scan_reg[IW-1:0];
                    blvl_next = cur.level;
                end
                if (scan_reg + 1'b1 >= count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                case (item_reg.mode)
                    MODE_CLEAR:
                    begin
                        count_next   = '0;
                        wfaults_next = '0;
                        casc_next    = 1'b0;
                        wstart_next  = item_reg.now_us;
                        top_next     = '0;
                    end
                    MODE_CHECK:
                    begin
                        if (elapsed >= window_reg)
                        begin
                            wstart_next  = item_reg.now_us;
                            wfaults_next = 32'(count_reg);
                            casc_next    = (32'(count_reg) >= limit_reg);
                        end
                        else
                        begin
                            casc_next = (wfaults_reg >= limit_reg);
                        end
                    end
                    default: ;
                endcase
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result assembled from next-state values, registered in the closing state
    out_item_t res_reg, res_next;
    logic      done_reg;
    entry_t    top_e, rd_e;
    logic      rd_ok;

    assign top_e = cells[top_next];
    assign rd_e  = cells[item_reg.entry_index[IW-1:0]];
    assign rd_ok = (item_reg.mode == MODE_READ) &&
                   ({1'b0, item_reg.entry_index} < 5'(count_reg)) &&
                   (int'(item_reg.entry_index) < MAX_ENTRIES);

    always_comb
    begin
        res_next = '0;
        res_next.ok          = (item_reg.mode == MODE_READ) ? rd_ok : ok_reg;
        res_next.evicted     = ev_reg;
        res_next.evicted_key = ev_reg ? evkey_reg : 32'd0;
        res_next.entry_count = 5'(count_next);
        if (count_next != '0)
        begin
            res_next.top_index = 4'(top_next);
            res_next.top_key   = top_e.key;
            res_next.top_level = top_e.level;
        end
        res_next.cascading = casc_next;
        if (rd_ok)
        begin
            res_next.read_key   = rd_e.key;
            res_next.read_level = rd_e.level;
            res_next.read_done  = rd_e.done;
            res_next.read_time  = rd_e.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            res_reg <= res_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
